### hdl/ptt_pkg.sv
// Shared types, codes and default sizes for the periodic timer table.
// Depends on nothing; every other file in hdl imports it.
`default_nettype none

package ptt_pkg;

   localparam int TIMER_SLOTS_DEF = 8;
   localparam int ID_SPACE_DEF    = 16;
   localparam int QUEUE_DEPTH     = 2;

   // Input kinds
   localparam logic [1:0] KIND_CREATE = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;

   // Result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // Commands passed from the front end to the engine
   localparam logic [1:0] OP_CREATE = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;
   localparam logic [1:0] OP_REPLY  = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] timer_id;
      logic [7:0] period;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       fired;
      logic [3:0] fired_id;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] op;
      logic [1:0] status;
      logic [3:0] timer_id;
      logic [7:0] period;
   } cmd_type;

   typedef struct packed {
      logic [3:0] ident;
      logic [7:0] remaining;
      logic [7:0] reload;
   } slot_type;

endpackage

`default_nettype wire

### hdl/ptt_front.sv
// Front end of the periodic timer table: decodes and range-checks requests
// and queues them as commands. Depends on ptt_pkg.
`default_nettype none

module ptt_front #(
   parameter int ID_SPACE = ptt_pkg::ID_SPACE_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ptt_pkg::req_type req_data,
   output logic                  cmd_valid,
   input  wire logic             cmd_ready,
   output ptt_pkg::cmd_type      cmd_data
);
   import ptt_pkg::*;

   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type              queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    count_ff, count_in;
   cmd_type              cmd_new;
   logic                 out_of_range;
   logic                 push, pop;

   // classify
   always_comb begin
      out_of_range     = ({28'd0, req_data.timer_id} >= 32'(ID_SPACE));
      cmd_new.timer_id = req_data.timer_id;
      cmd_new.period   = req_data.period;
      cmd_new.status   = ST_OK;
      cmd_new.op       = OP_REPLY;
      unique case (req_data.kind)
         KIND_CREATE: begin
            cmd_new.op     = out_of_range ? OP_REPLY : OP_CREATE;
            cmd_new.status = out_of_range ? ST_RANGE : ST_OK;
         end
         KIND_DELETE: begin
            cmd_new.op     = out_of_range ? OP_REPLY : OP_DELETE;
            cmd_new.status = out_of_range ? ST_RANGE : ST_OK;
         end
         KIND_TICK: begin
            cmd_new.op = OP_TICK;
         end
         default: begin
            cmd_new.op = OP_REPLY;
         end
      endcase
   end

   assign req_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = queue_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

`default_nettype wire

### hdl/ptt_engine.sv
// Back end of the periodic timer table: slot memory, fill count, slot walk
// and the result register. Depends on ptt_pkg.
`default_nettype none

module ptt_engine #(
   parameter int TIMER_SLOTS = ptt_pkg::TIMER_SLOTS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   output logic                  cmd_ready,
   input  wire ptt_pkg::cmd_type cmd_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ptt_pkg::rsp_type      rsp_data
);
   import ptt_pkg::*;

   localparam int ADDR_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;

   slot_type             slot_mem [TIMER_SLOTS];
   slot_type             rd_data_ff;

   logic [1:0]           state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [CNT_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                 ev_vld_ff, ev_vld_in;
   logic [ADDR_W-1:0]    ev_idx_ff, ev_idx_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic                 pend_vld_ff, pend_vld_in;
   logic [3:0]           pend_id_ff, pend_id_in;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   logic                 rd_en, wr_en;
   logic [ADDR_W-1:0]    rd_addr, wr_addr;
   slot_type             wr_data;
   logic                 emit, advance;
   rsp_type              emit_data;
   logic                 issue_ok, match, walk_done;

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      rd_idx_in   = rd_idx_ff;
      ev_vld_in   = ev_vld_ff;
      ev_idx_in   = ev_idx_ff;
      fill_in     = fill_ff;
      pend_vld_in = pend_vld_ff;
      pend_id_in  = pend_id_ff;
      rd_en       = 1'b0;
      rd_addr     = rd_idx_ff[ADDR_W-1:0];
      wr_en       = 1'b0;
      wr_addr     = ev_idx_ff;
      wr_data     = rd_data_ff;
      emit        = 1'b0;
      emit_data   = '{status: ST_OK, fired: 1'b0, fired_id: 4'd0, last: 1'b1};

      issue_ok  = (rd_idx_ff < fill_ff);
      match     = ev_vld_ff && (rd_data_ff.ident == cmd_ff.timer_id);
      walk_done = !ev_vld_ff && !issue_ok;

      unique case (state_ff) inside
         S_IDLE: begin
            ev_vld_in = 1'b0;
            if (cmd_valid) begin
               cmd_in = cmd_data;
               if (cmd_data.op == OP_REPLY) begin
                  emit             = 1'b1;
                  emit_data.status = cmd_data.status;
               end else begin
                  state_in    = S_SCAN;
                  rd_idx_in   = '0;
                  pend_vld_in = 1'b0;
               end
            end
         end

         S_SCAN, S_SHIFT: begin
            // issue the next slot read, evaluate the one read last cycle
            rd_en     = issue_ok;
            ev_vld_in = issue_ok;
            ev_idx_in = rd_idx_ff[ADDR_W-1:0];
            if (issue_ok) begin
               rd_idx_in = CNT_W'(rd_idx_ff + 1'b1);
            end

            if (state_ff == S_SHIFT) begin
               if (ev_vld_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = ADDR_W'(ev_idx_ff - 1'b1);
                  wr_data = rd_data_ff;
               end
               if (walk_done) begin
                  fill_in  = CNT_W'(fill_ff - 1'b1);
                  emit     = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               unique case (cmd_ff.op)
                  OP_CREATE: begin
                     if (match) begin
                        wr_en     = 1'b1;
                        wr_data   = '{ident: rd_data_ff.ident,
                                      remaining: cmd_ff.period,
                                      reload: cmd_ff.period};
                        emit      = 1'b1;
                        ev_vld_in = 1'b0;
                        state_in  = S_IDLE;
                     end else if (walk_done) begin
                        emit     = 1'b1;
                        state_in = S_IDLE;
                        if (fill_ff < CNT_W'(TIMER_SLOTS)) begin
                           wr_en   = 1'b1;
                           wr_addr = fill_ff[ADDR_W-1:0];
                           wr_data = '{ident: cmd_ff.timer_id,
                                       remaining: cmd_ff.period,
                                       reload: cmd_ff.period};
                           fill_in = CNT_W'(fill_ff + 1'b1);
                        end else begin
                           emit_data.status = ST_FULL;
                        end
                     end
                  end

                  OP_DELETE: begin
                     if (match) begin
                        // restart the walk one past the hit and copy down
                        rd_en     = 1'b0;
                        ev_vld_in = 1'b0;
                        rd_idx_in = CNT_W'(CNT_W'(ev_idx_ff) + 1'b1);
                        state_in  = S_SHIFT;
                     end else if (walk_done) begin
                        emit     = 1'b1;
                        state_in = S_IDLE;
                     end
                  end

                  OP_TICK: begin
                     if (ev_vld_ff) begin
                        wr_en = 1'b1;
                        if (rd_data_ff.remaining != 8'd0) begin
                           wr_data.remaining = rd_data_ff.remaining - 8'd1;
                        end else begin
                           wr_data.remaining = rd_data_ff.reload;
                           // hold the newest firing back until we know if it is last
                           if (pend_vld_ff) begin
                              emit      = 1'b1;
                              emit_data = '{status: ST_OK, fired: 1'b1,
                                            fired_id: pend_id_ff, last: 1'b0};
                           end
                           pend_vld_in = 1'b1;
                           pend_id_in  = rd_data_ff.ident;
                        end
                     end else if (walk_done) begin
                        emit     = 1'b1;
                        state_in = S_IDLE;
                        if (pend_vld_ff) begin
                           emit_data = '{status: ST_OK, fired: 1'b1,
                                         fired_id: pend_id_ff, last: 1'b1};
                        end
                     end
                  end

                  default: begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // freeze everything while a result cannot be placed
      advance   = !(emit && rsp_valid_ff && !rsp_ready);
      cmd_ready = (state_ff == S_IDLE) && advance;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         rd_idx_ff   <= '0;
         ev_vld_ff   <= 1'b0;
         fill_ff     <= '0;
         pend_vld_ff <= 1'b0;
      end else if (advance) begin
         state_ff    <= state_in;
         rd_idx_ff   <= rd_idx_in;
         ev_vld_ff   <= ev_vld_in;
         fill_ff     <= fill_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cmd_ff     <= cmd_in;
         ev_idx_ff  <= ev_idx_in;
         pend_id_ff <= pend_id_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && advance) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (rd_en && advance) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit && advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit && advance) begin
         rsp_data_ff <= emit_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### hdl/periodic_timer_table.sv
// Periodic timer table. The engine walks the N occupied slots, one slot read
// per cycle while no waiting result holds it: a create or tick walks all of
// them, a create that updates an existing entry stops at its slot, a delete
// searches to the hit, then copies down the rest; a rejected or meaningless
// request is answered without a walk. The engine takes a new command only
// once it is done with the last. Reset clears the fill count and the queue.
`default_nettype none

module periodic_timer_table #(
   parameter int TIMER_SLOTS = ptt_pkg::TIMER_SLOTS_DEF,
   parameter int ID_SPACE    = ptt_pkg::ID_SPACE_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ptt_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ptt_pkg::rsp_type      rsp_data
);
   import ptt_pkg::*;

   // Command transactions between the decoder and the engine
   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd_data;

   // Decode each request, reject out-of-range ids early and queue the
   // command, so the requester can keep going while the engine walks.
   ptt_front #(
      .ID_SPACE (ID_SPACE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data)
   );

   // Walk the slot memory: search and update on create, search and copy
   // down on delete, count down and report firings on tick. The result
   // register inside lets the engine run on while a result waits.
   ptt_engine #(
      .TIMER_SLOTS (TIMER_SLOTS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
